// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

    // Widths of the fields on the item channels.
    localparam int CMD_W   = 1;
    localparam int PAGE_W  = 12;
    localparam int STAT_W  = 2;
    localparam int ORDER_W = 4;

    // Request codes carried in the command field.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 2'd0,
        ST_NO_FREE     = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_BAD_REQUEST = 2'd3
    } status_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_FAIL,
        OP_READ_IDX,
        OP_INC_I,
        OP_TAKE,
        OP_UL_PREV,
        OP_UL_NEXT,
        OP_UL_CLEAR,
        OP_SPLIT_PUSH,
        OP_PUSH_FIX,
        OP_GRANT,
        OP_FREE_USE,
        OP_READ_B,
        OP_ABSORB,
        OP_FINAL_PUSH,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic init_last;
        logic is_free;
        logic bad;
        logic search_end;
        logic head_hit;
        logic split_more;
        logic in_use;
        logic merge_try;
        logic buddy_ok;
    } dp_stat_t;

endpackage

// ===== rtl/bpa_datapath.sv =====
module bpa_datapath #(
    parameter int NUM_PAGES  = 4096,
    parameter int TOP_ORDER  = 11,
    parameter int NUM_ORDERS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpa_pkg::dp_cmd_t              cmd,
    output bpa_pkg::dp_stat_t             stat,
    input  logic [bpa_pkg::CMD_W-1:0]     command,
    input  logic [bpa_pkg::PAGE_W-1:0]    page_count,
    input  logic [bpa_pkg::PAGE_W-1:0]    page_index,
    output logic [bpa_pkg::STAT_W-1:0]    status,
    output logic [bpa_pkg::PAGE_W-1:0]    granted_page,
    output logic [bpa_pkg::ORDER_W-1:0]   block_order
);
    import bpa_pkg::*;

    localparam int PW   = $clog2(NUM_PAGES);
    localparam int LW   = $clog2(NUM_PAGES + 1);
    localparam int OW   = $clog2(TOP_ORDER + 2);
    localparam int STEP = 1 << TOP_ORDER;
    localparam int POOL = (NUM_PAGES >> TOP_ORDER) << TOP_ORDER;
    localparam int NONE = NUM_PAGES;
    localparam int LAST = NUM_PAGES - 1;

    // Per-page state memories.
    logic [OW-1:0] order_mem [NUM_PAGES];
    logic          use_mem   [NUM_PAGES];
    logic [LW-1:0] fwd_mem   [NUM_PAGES];
    logic [LW-1:0] back_mem  [NUM_PAGES];

    logic [OW-1:0] rd_order_reg;
    logic          rd_use_reg;
    logic [LW-1:0] rd_fwd_reg;
    logic [LW-1:0] rd_back_reg;

    logic [LW-1:0] head_reg [NUM_ORDERS];

    logic [PW-1:0]      init_cnt_reg, init_cnt_next;
    logic               cmd_free_reg, cmd_free_next;
    logic [PAGE_W-1:0]  count_reg, count_next;
    logic [PAGE_W-1:0]  idx_reg, idx_next;
    logic [OW-1:0]      k_reg, k_next;
    logic [OW-1:0]      i_reg, i_next;
    logic [OW-1:0]      lvl_reg, lvl_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [PW-1:0]      u_reg, u_next;
    logic [PW-1:0]      node_reg, node_next;
    logic [LW-1:0]      h_reg, h_next;
    status_t            res_status_reg, res_status_next;
    logic [PAGE_W-1:0]  res_page_reg, res_page_next;
    logic [ORDER_W-1:0] res_order_reg, res_order_next;
    status_t            out_status_reg, out_status_next;
    logic [PAGE_W-1:0]  out_page_reg, out_page_next;
    logic [ORDER_W-1:0] out_order_reg, out_order_next;

    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] wr_addr;
    logic          we_order, we_use, we_fwd, we_back;
    logic [OW-1:0] wd_order;
    logic          wd_use;
    logic [LW-1:0] wd_fwd, wd_back;
    logic          head_we;
    logic [OW-1:0] head_wsel;
    logic [LW-1:0] head_wdata;

    logic [LW-1:0] head_sel, head_lo, head_k;
    logic [OW-1:0] lo_order;
    logic [31:0]   half32, buddy32, init32;
    logic          init_top;

    function automatic logic [OW-1:0] order_of(input logic [PAGE_W-1:0] cnt);
        logic [PAGE_W-1:0] m;
        int r;
        m = cnt - PAGE_W'(1);
        r = 0;
        for (int b = 0; b < PAGE_W; b++)
        begin
            if (m[b])
            begin
                r = b + 1;
            end
        end
        return OW'(r);
    endfunction

    assign lo_order = i_reg - OW'(1);

    // Free-list heads at the orders that the sequence needs.
    always_comb
    begin
        head_sel = LW'(NONE);
        head_lo  = LW'(NONE);
        head_k   = LW'(NONE);
        for (int e = 0; e < NUM_ORDERS; e++)
        begin
            if (int'(i_reg) == e)
            begin
                head_sel = head_reg[e];
            end
            if (int'(lo_order) == e)
            begin
                head_lo = head_reg[e];
            end
            if (int'(k_reg) == e)
            begin
                head_k = head_reg[e];
            end
        end
    end

    assign half32   = 32'(p_reg) + (32'd1 << i_reg) / 2;
    assign buddy32  = 32'(p_reg) ^ (32'd1 << k_reg);
    assign init32   = 32'(init_cnt_reg);
    assign init_top = (init32 < POOL) && ((init32 & (STEP - 1)) == 32'd0);

    always_comb
    begin
        stat.init_last  = (init_cnt_reg == PW'(LAST));
        stat.is_free    = cmd_free_reg;
        stat.bad        = cmd_free_reg ? (32'(idx_reg) >= POOL)
                        : ((count_reg == '0) || (32'(count_reg) > STEP));
        stat.search_end = (32'(i_reg) > TOP_ORDER) || (32'(i_reg) >= NUM_ORDERS);
        stat.head_hit   = (32'(head_sel) < NUM_PAGES);
        stat.split_more = (i_reg > k_reg);
        stat.in_use     = rd_use_reg;
        stat.merge_try  = (32'(k_reg) < TOP_ORDER) && (buddy32 < POOL);
        stat.buddy_ok   = !rd_use_reg && (rd_order_reg == k_reg);
    end

    always_comb
    begin
        init_cnt_next   = init_cnt_reg;
        cmd_free_next   = cmd_free_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        lvl_next        = lvl_reg;
        p_next          = p_reg;
        u_next          = u_reg;
        node_next       = node_reg;
        h_next          = h_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_order_next  = res_order_reg;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        out_order_next  = out_order_reg;
        rd_en      = 1'b0;
        rd_addr    = p_reg;
        wr_addr    = p_reg;
        we_order   = 1'b0;
        we_use     = 1'b0;
        we_fwd     = 1'b0;
        we_back    = 1'b0;
        wd_order   = '0;
        wd_use     = 1'b0;
        wd_fwd     = LW'(NONE);
        wd_back    = LW'(NONE);
        head_we    = 1'b0;
        head_wsel  = lvl_reg;
        head_wdata = LW'(NONE);
        case (cmd.op)
            OP_INIT:
            begin
                wr_addr  = init_cnt_reg;
                we_order = 1'b1;
                we_use   = 1'b1;
                we_fwd   = 1'b1;
                we_back  = 1'b1;
                wd_order = init_top ? OW'(TOP_ORDER) : '0;
                wd_fwd   = (init_top && (init32 + STEP < POOL))
                         ? LW'(init32 + STEP) : LW'(NONE);
                wd_back  = (init_top && (init32 != 32'd0))
                         ? LW'(init32 - STEP) : LW'(NONE);
                init_cnt_next = init_cnt_reg + PW'(1);
            end
            OP_LOAD:
            begin
                cmd_free_next = (command == CMD_FREE);
                count_next    = page_count;
                idx_next      = page_index;
                k_next        = order_of(page_count);
                i_next        = order_of(page_count);
            end
            OP_FAIL:
            begin
                res_status_next = cmd.code;
                res_page_next   = '0;
                res_order_next  = '0;
            end
            OP_READ_IDX:
            begin
                rd_en   = 1'b1;
                rd_addr = PW'(idx_reg);
                p_next  = PW'(idx_reg);
            end
            OP_INC_I:
            begin
                i_next = i_reg + OW'(1);
            end
            OP_TAKE:
            begin
                rd_en    = 1'b1;
                rd_addr  = PW'(head_sel);
                p_next   = PW'(head_sel);
                u_next   = PW'(head_sel);
                lvl_next = i_reg;
            end
            OP_UL_PREV:
            begin
                if (32'(rd_back_reg) < NUM_PAGES)
                begin
                    wr_addr = PW'(rd_back_reg);
                    we_fwd  = 1'b1;
                    wd_fwd  = rd_fwd_reg;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wsel  = lvl_reg;
                    head_wdata = rd_fwd_reg;
                end
            end
            OP_UL_NEXT:
            begin
                if (32'(rd_fwd_reg) < NUM_PAGES)
                begin
                    wr_addr = PW'(rd_fwd_reg);
                    we_back = 1'b1;
                    wd_back = rd_back_reg;
                end
            end
            OP_UL_CLEAR:
            begin
                wr_addr = u_reg;
                we_fwd  = 1'b1;
                we_back = 1'b1;
            end
            OP_SPLIT_PUSH:
            begin
                wr_addr    = PW'(half32);
                we_order   = 1'b1;
                we_use     = 1'b1;
                we_fwd     = 1'b1;
                we_back    = 1'b1;
                wd_order   = lo_order;
                wd_fwd     = head_lo;
                h_next     = head_lo;
                node_next  = PW'(half32);
                head_we    = 1'b1;
                head_wsel  = lo_order;
                head_wdata = LW'(half32);
                i_next     = lo_order;
            end
            OP_PUSH_FIX:
            begin
                if (32'(h_reg) < NUM_PAGES)
                begin
                    wr_addr = PW'(h_reg);
                    we_back = 1'b1;
                    wd_back = LW'(node_reg);
                end
            end
            OP_GRANT:
            begin
                we_order        = 1'b1;
                we_use          = 1'b1;
                wd_order        = k_reg;
                wd_use          = 1'b1;
                res_status_next = ST_OK;
                res_page_next   = PAGE_W'(p_reg);
                res_order_next  = ORDER_W'(k_reg);
            end
            OP_FREE_USE:
            begin
                we_use = 1'b1;
                k_next = rd_order_reg;
            end
            OP_READ_B:
            begin
                rd_en    = 1'b1;
                rd_addr  = PW'(buddy32);
                u_next   = PW'(buddy32);
                lvl_next = k_reg;
            end
            OP_ABSORB:
            begin
                we_order = 1'b1;
                if (u_reg < p_reg)
                begin
                    wr_addr = p_reg;
                    p_next  = u_reg;
                end
                else
                begin
                    wr_addr = u_reg;
                end
                k_next = k_reg + OW'(1);
            end
            OP_FINAL_PUSH:
            begin
                we_order        = 1'b1;
                we_use          = 1'b1;
                we_fwd          = 1'b1;
                we_back         = 1'b1;
                wd_order        = k_reg;
                wd_fwd          = head_k;
                h_next          = head_k;
                node_next       = p_reg;
                head_we         = 1'b1;
                head_wsel       = k_reg;
                head_wdata      = LW'(p_reg);
                res_status_next = ST_OK;
                res_page_next   = '0;
                res_order_next  = ORDER_W'(k_reg);
            end
            OP_PUBLISH:
            begin
                out_status_next = res_status_reg;
                out_page_next   = res_page_reg;
                out_order_next  = res_order_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_order)
        begin
            order_mem[wr_addr] <= wd_order;
        end
        if (we_use)
        begin
            use_mem[wr_addr] <= wd_use;
        end
        if (we_fwd)
        begin
            fwd_mem[wr_addr] <= wd_fwd;
        end
        if (we_back)
        begin
            back_mem[wr_addr] <= wd_back;
        end
        if (rd_en)
        begin
            rd_order_reg <= order_mem[rd_addr];
            rd_use_reg   <= use_mem[rd_addr];
            rd_fwd_reg   <= fwd_mem[rd_addr];
            rd_back_reg  <= back_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg <= '0;
            for (int e = 0; e < NUM_ORDERS; e++)
            begin
                head_reg[e] <= ((e == TOP_ORDER) && (POOL > 0)) ? '0 : LW'(NONE);
            end
        end
        else
        begin
            init_cnt_reg <= init_cnt_next;
            for (int e = 0; e < NUM_ORDERS; e++)
            begin
                if (head_we && (int'(head_wsel) == e))
                begin
                    head_reg[e] <= head_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_free_reg   <= cmd_free_next;
        count_reg      <= count_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        i_reg          <= i_next;
        lvl_reg        <= lvl_next;
        p_reg          <= p_next;
        u_reg          <= u_next;
        node_reg       <= node_next;
        h_reg          <= h_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_order_reg  <= res_order_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
        out_order_reg  <= out_order_next;
    end

    assign status       = out_status_reg;
    assign granted_page = out_page_reg;
    assign block_order  = out_order_reg;

    // A split never goes below the wanted order.
    a_split_above_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SPLIT_PUSH |-> i_reg > k_reg)
        else $error("split issued at or below target order");

    // A block is only taken from a non-empty list.
    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_TAKE |-> 32'(head_sel) < NUM_PAGES)
        else $error("block taken from an empty list");

    // A grant follows only a valid allocate request.
    a_grant_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_GRANT |-> !cmd_free_reg && !stat.bad)
        else $error("grant on a free or bad request");

endmodule

// ===== rtl/bpa_ctrl.sv =====
module bpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  bpa_pkg::dp_stat_t stat,
    output bpa_pkg::dp_cmd_t  cmd
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_UL1,
        S_UL2,
        S_UL3,
        S_SPLIT,
        S_FIX,
        S_FWAIT,
        S_MERGE,
        S_BWAIT,
        S_ABSORB,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.code       = ST_OK;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op = OP_INIT;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.bad)
                begin
                    cmd.op     = OP_FAIL;
                    cmd.code   = ST_BAD_REQUEST;
                    state_next = S_DONE;
                end
                else if (stat.is_free)
                begin
                    cmd.op     = OP_READ_IDX;
                    state_next = S_FWAIT;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.search_end)
                begin
                    cmd.op     = OP_FAIL;
                    cmd.code   = ST_NO_FREE;
                    state_next = S_DONE;
                end
                else if (stat.head_hit)
                begin
                    cmd.op     = OP_TAKE;
                    state_next = S_UL1;
                end
                else
                begin
                    cmd.op = OP_INC_I;
                end
            end
            S_UL1:
            begin
                cmd.op     = OP_UL_PREV;
                state_next = S_UL2;
            end
            S_UL2:
            begin
                cmd.op     = OP_UL_NEXT;
                state_next = S_UL3;
            end
            S_UL3:
            begin
                cmd.op     = OP_UL_CLEAR;
                state_next = stat.is_free ? S_ABSORB : S_SPLIT;
            end
            S_SPLIT:
            begin
                if (stat.split_more)
                begin
                    cmd.op     = OP_SPLIT_PUSH;
                    state_next = S_FIX;
                end
                else
                begin
                    cmd.op     = OP_GRANT;
                    state_next = S_DONE;
                end
            end
            S_FIX:
            begin
                cmd.op     = OP_PUSH_FIX;
                state_next = stat.is_free ? S_DONE : S_SPLIT;
            end
            S_FWAIT:
            begin
                if (!stat.in_use)
                begin
                    cmd.op     = OP_FAIL;
                    cmd.code   = ST_DOUBLE_FREE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_FREE_USE;
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                if (stat.merge_try)
                begin
                    cmd.op     = OP_READ_B;
                    state_next = S_BWAIT;
                end
                else
                begin
                    cmd.op     = OP_FINAL_PUSH;
                    state_next = S_FIX;
                end
            end
            S_BWAIT:
            begin
                if (stat.buddy_ok)
                begin
                    state_next = S_UL1;
                end
                else
                begin
                    cmd.op     = OP_FINAL_PUSH;
                    state_next = S_FIX;
                end
            end
            S_ABSORB:
            begin
                cmd.op     = OP_ABSORB;
                state_next = S_MERGE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // An accepted request always starts decoding on the next cycle.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DECODE)
        else $error("accepted request did not enter decode");

    // No result is offered while the memories are being initialized.
    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INIT |-> !out_valid)
        else $error("result offered during initialization");

    // Publishing a result raises the output valid.
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_PUBLISH |=> out_valid)
        else $error("published result not offered");

endmodule

// ===== rtl/buddy_page_allocator.sv =====
// Allocate: searches the orders upward from the wanted one for a free block, unlinks it and
// splits it down to the wanted order. Free: checks the page, then merges it with free buddies.
// One request at a time: no new request is taken until the last one is finished.
// Reset: asynchronous, active low; afterwards the page memories are initialized one page
// per cycle, during which no request is taken.
module buddy_page_allocator #(
    parameter int NUM_PAGES  = 4096,
    parameter int TOP_ORDER  = 11,
    parameter int NUM_ORDERS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [bpa_pkg::CMD_W-1:0]   command,
    input  logic [bpa_pkg::PAGE_W-1:0]  page_count,
    input  logic [bpa_pkg::PAGE_W-1:0]  page_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bpa_pkg::STAT_W-1:0]  status,
    output logic [bpa_pkg::PAGE_W-1:0]  granted_page,
    output logic [bpa_pkg::ORDER_W-1:0] block_order
);
    import bpa_pkg::*;

    // The controller sequences each request as a string of datapath operations.
    // The datapath owns the per-page memories (order, in-use flag and the two
    // free-list links), the free-list heads and the result registers.
    // The finished result sits in an output register, so a new request can be
    // taken while the previous result still waits for its transfer.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpa_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .TOP_ORDER  (TOP_ORDER),
        .NUM_ORDERS (NUM_ORDERS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .command      (command),
        .page_count   (page_count),
        .page_index   (page_index),
        .status       (status),
        .granted_page (granted_page),
        .block_order  (block_order)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import bpa_pkg::*;

    // Pool geometry of the block as instantiated with its default parameters.
    localparam int POOL_PAGES  = 4096;
    localparam int TOP_ORD     = 11;
    localparam int ORDER_CNT   = 12;
    localparam int NO_LINK     = POOL_PAGES;
    localparam int POOL_END    = (POOL_PAGES >> TOP_ORD) << TOP_ORD;
    localparam int RANDOM_REQS = 1600;
    // Reset clears the page memories one page per cycle, so the stall-free
    // limit must cover that pass plus the slowest request and both idle bursts.
    localparam int HANG_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 64;

    // One result expected from the allocator.
    typedef struct {
        status_t         code;
        logic [PAGE_W-1:0]  page;
        logic [ORDER_W-1:0] order;
    } alloc_result_t;

    // The scoreboard holds a private copy of the free lists and page tables.
    // Every accepted request advances that copy and queues the answer the
    // block must give, and every returned answer is matched against the
    // oldest queued one.
    class buddy_scoreboard;
        logic [3:0]    pg_order[POOL_PAGES];
        bit            pg_used[POOL_PAGES];
        int            nxt[POOL_PAGES];
        int            prv[POOL_PAGES];
        int            heads[ORDER_CNT];
        alloc_result_t answers[$];
        int            live_blocks[$];
        int            errors;

        function new();
            int i;
            errors = 0;
            for (i = 0; i < POOL_PAGES; i++)
            begin
                pg_order[i] = 0;
                pg_used[i]  = 0;
                nxt[i]      = NO_LINK;
                prv[i]      = NO_LINK;
            end
            for (i = 0; i < ORDER_CNT; i++)
                heads[i] = NO_LINK;
            // All of the pool starts as top-order blocks chained upward.
            for (i = 0; i < POOL_END; i += (1 << TOP_ORD))
            begin
                pg_order[i] = 4'(TOP_ORD);
                prv[i] = (i == 0) ? NO_LINK : i - (1 << TOP_ORD);
                nxt[i] = (i + (1 << TOP_ORD) < POOL_END) ? i + (1 << TOP_ORD) : NO_LINK;
            end
            heads[TOP_ORD] = 0;
        endfunction

        function void push_free(int k, int p);
            int h;
            h = heads[k];
            prv[p] = NO_LINK;
            nxt[p] = h;
            if (h < POOL_PAGES)
                prv[h] = p;
            heads[k] = p;
        endfunction

        function void unlink_free(int k, int p);
            int pr;
            int nx;
            pr = prv[p];
            nx = nxt[p];
            if (pr < POOL_PAGES)
                nxt[pr] = nx;
            else
                heads[k] = nx;
            if (nx < POOL_PAGES)
                prv[nx] = pr;
            prv[p] = NO_LINK;
            nxt[p] = NO_LINK;
        endfunction

        function void drop_live(int p);
            int i;
            for (i = 0; i < live_blocks.size(); i++)
                if (live_blocks[i] == p)
                begin
                    live_blocks.delete(i);
                    return;
                end
        endfunction

        // Apply one accepted request and queue the answer it must produce.
        function void note_request(logic [CMD_W-1:0] cmd, int count, int idx);
            alloc_result_t r;
            int k;
            int i;
            int j;
            int p;
            int b;
            r.code  = ST_OK;
            r.page  = '0;
            r.order = '0;
            if (cmd == CMD_ALLOC)
            begin
                if (count == 0 || count > (1 << TOP_ORD))
                    r.code = ST_BAD_REQUEST;
                else
                begin
                    k = 0;
                    while ((1 << k) < count)
                        k++;
                    i = k;
                    while (i <= TOP_ORD && heads[i] >= POOL_PAGES)
                        i++;
                    if (i > TOP_ORD)
                        r.code = ST_NO_FREE;
                    else
                    begin
                        p = heads[i];
                        unlink_free(i, p);
                        // Each split leaves its upper half on the next lower list.
                        for (j = i; j > k; j--)
                        begin
                            b = p + (1 << (j - 1));
                            pg_order[b] = 4'(j - 1);
                            pg_used[b]  = 0;
                            push_free(j - 1, b);
                        end
                        pg_order[p] = 4'(k);
                        pg_used[p]  = 1;
                        r.page  = PAGE_W'(p);
                        r.order = ORDER_W'(k);
                        live_blocks.push_back(p);
                    end
                end
            end
            else
            begin
                if (idx >= POOL_END)
                    r.code = ST_BAD_REQUEST;
                else if (!pg_used[idx])
                    r.code = ST_DOUBLE_FREE;
                else
                begin
                    p = idx;
                    k = pg_order[idx];
                    pg_used[p] = 0;
                    drop_live(p);
                    // Coalesce with free buddies of the same order; an absorbed
                    // head loses its order so nothing stale is left behind.
                    while (k < TOP_ORD)
                    begin
                        b = p ^ (1 << k);
                        if (b >= POOL_END || pg_used[b] || pg_order[b] != k)
                            break;
                        unlink_free(k, b);
                        if (b < p)
                        begin
                            pg_order[p] = 0;
                            p = b;
                        end
                        else
                            pg_order[b] = 0;
                        k++;
                    end
                    pg_order[p] = 4'(k);
                    push_free(k, p);
                    r.order = ORDER_W'(k);
                end
            end
            answers.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] code, logic [PAGE_W-1:0] page,
                                   logic [ORDER_W-1:0] order);
            alloc_result_t e;
            if (answers.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, %s %0d page %0d order %0d",
                         $time, "actual status", code, page, order);
                errors++;
                return;
            end
            e = answers.pop_front();
            if (code !== e.code)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.code, code);
                errors++;
            end
            if (page !== e.page)
            begin
                $display("%0t: granted_page expected %0d actual %0d", $time, e.page, page);
                errors++;
            end
            if (order !== e.order)
            begin
                $display("%0t: block_order expected %0d actual %0d", $time, e.order, order);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_W-1:0]    command;
    logic [PAGE_W-1:0]   page_count;
    logic [PAGE_W-1:0]   page_index;
    logic                out_valid;
    logic                out_stall;
    logic [STAT_W-1:0]   status;
    logic [PAGE_W-1:0]   granted_page;
    logic [ORDER_W-1:0]  block_order;

    buddy_scoreboard sb;
    bit              idling;
    int              stall_left;
    int              quiet_cycles;

    buddy_page_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .page_count   (page_count),
        .page_index   (page_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .granted_page (granted_page),
        .block_order  (block_order)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one request and hold it until the block takes the transfer.
    // Outputs are sampled right after the edge, before any register update
    // of that edge is visible, so the sampled stall is the one the edge saw.
    task automatic send_request(logic [CMD_W-1:0] cmd, int count, int idx);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        page_count <= count[PAGE_W-1:0];
        page_index <= idx[PAGE_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(cmd, count, idx);
    endtask

    // Allocation sizes lean small so that the lists stay busy at every
    // order, with an occasional large block to drive deep splits.
    function automatic int pick_count();
        int r;
        int ord;
        r = $urandom_range(0, 9);
        if (r < 6)
            ord = $urandom_range(0, 3);
        else if (r < 9)
            ord = $urandom_range(0, 8);
        else
            ord = $urandom_range(0, TOP_ORD);
        if (ord == 0)
            return 1;
        return $urandom_range((1 << ord) / 2 + 1, 1 << ord);
    endfunction

    // Receiver side: random stall bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idling && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_result(status, granted_page, block_order);
    end

    // Watchdog: ends the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int n;
        int pick;
        sb           = new();
        idling       = 1'b0;
        stall_left   = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_ALLOC;
        page_count   = '0;
        page_index   = '0;
        out_stall    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: bad counts, whole-pool grants, exhaustion, double
        // and interior frees, and a split followed by a full merge back.
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_ALLOC, 4095, 4095);
        send_request(CMD_ALLOC, 2049, 0);
        send_request(CMD_ALLOC, 2048, 0);
        send_request(CMD_ALLOC, 2048, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 0, 2048);
        send_request(CMD_FREE, 0, 2048);
        send_request(CMD_FREE, 4095, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_ALLOC, 3, 0);
        send_request(CMD_ALLOC, 1024, 0);
        send_request(CMD_FREE, 0, 2049);
        send_request(CMD_FREE, 0, 4095);
        send_request(CMD_FREE, 0, 2048);
        send_request(CMD_FREE, 0, 2052);
        send_request(CMD_FREE, 0, 3072);
        send_request(CMD_FREE, 0, 0);
        send_request(CMD_FREE, 0, 2048);
        send_request(CMD_ALLOC, 2048, 0);
        send_request(CMD_ALLOC, 2048, 0);
        send_request(CMD_FREE, 0, 0);
        send_request(CMD_FREE, 0, 2048);

        // Random part. Most requests are well formed: allocations of
        // plausible sizes and frees of blocks that are really allocated.
        // The rest is noise on every field. Idling toggles in stretches and
        // is off for the final stretch.
        for (n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 200 == 0)
                idling = (n < RANDOM_REQS - 200) && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_request(CMD_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 4095));
            else if (pick == 1)
                send_request(CMD_FREE, $urandom_range(0, 4095), $urandom_range(0, 4095));
            else if (pick < 11 && sb.live_blocks.size() > 0)
                send_request(CMD_FREE, $urandom_range(0, 4095),
                             sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)]);
            else
                send_request(CMD_ALLOC, pick_count(), $urandom_range(0, 4095));
        end
        in_valid <= 1'b0;

        // Drain: the watchdog bounds this wait if results stop coming.
        while (sb.answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
